/* hw/rtl/mcl_pkg.sv */
`timescale 1ns / 1ps
// shared types and codes for the metamath character lexer
package mcl_pkg;

    localparam int unsigned MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_WHITE          = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TOKEN          = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOLLAR         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COMMENT        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COMMENT_DOLLAR = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INCLUDE        = 3'd5;
    localparam logic [MODE_W-1:0] MODE_INCLUDE_DOLLAR = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ERROR          = 3'd7;

    localparam logic [2:0] EV_TOKEN_BYTE   = 3'd0;
    localparam logic [2:0] EV_TOKEN_END    = 3'd1;
    localparam logic [2:0] EV_COMMENT_BYTE = 3'd2;
    localparam logic [2:0] EV_COMMENT_END  = 3'd3;
    localparam logic [2:0] EV_INCLUDE_BYTE = 3'd4;
    localparam logic [2:0] EV_INCLUDE_END  = 3'd5;
    localparam logic [2:0] EV_ERROR        = 3'd6;

    localparam logic [2:0] ERR_NONE           = 3'd0;
    localparam logic [2:0] ERR_DOLLAR_MID     = 3'd1;
    localparam logic [2:0] ERR_BROKEN_DOLLAR  = 3'd2;
    localparam logic [2:0] ERR_EOF_IN_SPAN    = 3'd3;
    localparam logic [2:0] ERR_NESTED_OPEN    = 3'd4;
    localparam logic [2:0] ERR_STRAY_CLOSE_C  = 3'd5;
    localparam logic [2:0] ERR_STRAY_CLOSE_I  = 3'd6;
    localparam logic [2:0] ERR_FORBIDDEN_CHAR = 3'd7;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // result queue depth, room for two items of two results
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [2:0] error_code;
        logic       last_of_run;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              span_has_content;
        logic [1:0]        num_res;
        result_t           res0;
        result_t           res1;
    } step_t;

endpackage

/* hw/rtl/mcl_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for lexer input and result items
interface mcl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

interface mcl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output event_res, output data_byte, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input event_res, input data_byte, input error_code,
                  input last_of_run, output ready);
endinterface

/* hw/rtl/mcl_step.sv */
`timescale 1ns / 1ps
// one lexer step: next mode and up to two results for one character
module mcl_step (
    input  logic [mcl_pkg::MODE_W-1:0] mode,
    input  logic                       span_has_content,
    input  logic [7:0]                 char_in,
    input  logic                       end_of_input,
    output mcl_pkg::step_t             step
);
    import mcl_pkg::*;

    function automatic result_t mk(input logic [2:0] ev, input logic [7:0] b,
                                   input logic [2:0] code);
        result_t r;
        r.event_res   = ev;
        r.data_byte   = b;
        r.error_code  = code;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic       is_valid;
    logic       is_white;
    logic       is_comment;
    logic       after_dollar;
    logic [2:0] ev_byte;
    logic [7:0] opener;
    logic [7:0] closer;
    step_t      s;

    assign is_valid = (char_in >= 8'd33) && (char_in <= 8'd126);
    assign is_white = (char_in == 8'd32) || (char_in == 8'd9) || (char_in == 8'd10) ||
                      (char_in == 8'd12) || (char_in == 8'd13);
    assign is_comment   = (mode == MODE_COMMENT) || (mode == MODE_COMMENT_DOLLAR);
    assign after_dollar = (mode == MODE_COMMENT_DOLLAR) || (mode == MODE_INCLUDE_DOLLAR);
    assign ev_byte = is_comment ? EV_COMMENT_BYTE : EV_INCLUDE_BYTE;
    assign opener  = is_comment ? CH_LPAREN : CH_LBRACK;
    assign closer  = is_comment ? CH_RPAREN : CH_RBRACK;

    always_comb
    begin
        s.mode             = mode;
        s.span_has_content = span_has_content;
        s.num_res          = 2'd0;
        s.res0             = mk(EV_ERROR, 8'd0, ERR_NONE);
        s.res1             = mk(EV_ERROR, 8'd0, ERR_NONE);

        if (mode == MODE_ERROR)
        begin
            // silent until reset
        end
        else if (end_of_input)
        begin
            if (mode == MODE_TOKEN)
            begin
                s.res0    = mk(EV_TOKEN_END, 8'd0, ERR_NONE);
                s.num_res = 2'd1;
                s.mode    = MODE_WHITE;
            end
            else if (mode == MODE_DOLLAR)
            begin
                s.res0    = mk(EV_ERROR, 8'd0, ERR_BROKEN_DOLLAR);
                s.num_res = 2'd1;
                s.mode    = MODE_ERROR;
            end
            else if (mode != MODE_WHITE)
            begin
                s.res0    = mk(EV_ERROR, 8'd0, ERR_EOF_IN_SPAN);
                s.num_res = 2'd1;
                s.mode    = MODE_ERROR;
            end
        end
        else
        begin
            unique case (mode) inside
                MODE_WHITE, MODE_TOKEN:
                begin
                    if (char_in == CH_DOLLAR)
                    begin
                        if (mode == MODE_TOKEN)
                        begin
                            s.res0    = mk(EV_ERROR, 8'd0, ERR_DOLLAR_MID);
                            s.num_res = 2'd1;
                            s.mode    = MODE_ERROR;
                        end
                        else
                        begin
                            s.mode = MODE_DOLLAR;
                        end
                    end
                    else if (is_valid)
                    begin
                        s.res0    = mk(EV_TOKEN_BYTE, char_in, ERR_NONE);
                        s.num_res = 2'd1;
                        s.mode    = MODE_TOKEN;
                    end
                    else if (is_white)
                    begin
                        if (mode == MODE_TOKEN)
                        begin
                            s.res0    = mk(EV_TOKEN_END, 8'd0, ERR_NONE);
                            s.num_res = 2'd1;
                            s.mode    = MODE_WHITE;
                        end
                    end
                    else
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_FORBIDDEN_CHAR);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                end
                MODE_DOLLAR:
                begin
                    if (char_in == CH_LPAREN || char_in == CH_LBRACK)
                    begin
                        s.mode = (char_in == CH_LPAREN) ? MODE_COMMENT : MODE_INCLUDE;
                        s.span_has_content = 1'b0;
                    end
                    else if (char_in == CH_RPAREN)
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_STRAY_CLOSE_C);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                    else if (char_in == CH_RBRACK)
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_STRAY_CLOSE_I);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                    else if (is_valid)
                    begin
                        s.res0    = mk(EV_TOKEN_BYTE, CH_DOLLAR, ERR_NONE);
                        s.res1    = mk(EV_TOKEN_BYTE, char_in, ERR_NONE);
                        s.num_res = 2'd2;
                        s.mode    = MODE_TOKEN;
                    end
                    else if (is_white)
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_BROKEN_DOLLAR);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                    else
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_FORBIDDEN_CHAR);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                end
                MODE_COMMENT, MODE_COMMENT_DOLLAR, MODE_INCLUDE, MODE_INCLUDE_DOLLAR:
                begin
                    if (!after_dollar)
                    begin
                        if (char_in == CH_DOLLAR)
                        begin
                            s.mode = is_comment ? MODE_COMMENT_DOLLAR : MODE_INCLUDE_DOLLAR;
                        end
                        else
                        begin
                            s.res0             = mk(ev_byte, char_in, ERR_NONE);
                            s.num_res          = 2'd1;
                            s.span_has_content = 1'b1;
                        end
                    end
                    else if (char_in == opener)
                    begin
                        s.res0    = mk(EV_ERROR, 8'd0, ERR_NESTED_OPEN);
                        s.num_res = 2'd1;
                        s.mode    = MODE_ERROR;
                    end
                    else if (char_in == closer)
                    begin
                        // empty comment ends silently, include end always shows
                        if (!is_comment)
                        begin
                            s.res0    = mk(EV_INCLUDE_END, 8'd0, ERR_NONE);
                            s.num_res = 2'd1;
                        end
                        else if (span_has_content)
                        begin
                            s.res0    = mk(EV_COMMENT_END, 8'd0, ERR_NONE);
                            s.num_res = 2'd1;
                        end
                        s.mode             = MODE_WHITE;
                        s.span_has_content = 1'b0;
                    end
                    else if (char_in == CH_DOLLAR)
                    begin
                        // stays after the dollar
                        s.res0             = mk(ev_byte, CH_DOLLAR, ERR_NONE);
                        s.num_res          = 2'd1;
                        s.span_has_content = 1'b1;
                    end
                    else
                    begin
                        s.res0             = mk(ev_byte, CH_DOLLAR, ERR_NONE);
                        s.res1             = mk(ev_byte, char_in, ERR_NONE);
                        s.num_res          = 2'd2;
                        s.span_has_content = 1'b1;
                        s.mode             = is_comment ? MODE_COMMENT : MODE_INCLUDE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (s.num_res == 2'd1)
        begin
            s.res0.last_of_run = 1'b1;
        end
        if (s.num_res == 2'd2)
        begin
            s.res1.last_of_run = 1'b1;
        end
    end

    assign step = s;

endmodule

/* hw/rtl/metamath_char_lexer.sv */
`timescale 1ns / 1ps
// metamath character lexer top level
// results of an item enter the result queue when the item is taken
// throughput: one item per cycle while the consumer takes one result per cycle;
// an item with two results may fill the 4-entry result queue and stall the input
// reset clears the lexer mode to between-tokens, drops queued results and clears errors
module metamath_char_lexer (
    input  logic      clk,
    input  logic      rst_n,
    mcl_in_if.sink    char_ch,
    mcl_out_if.source event_ch
);
    import mcl_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              content_reg;
    logic              content_next;
    result_t           queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    step_t             step;
    logic              take_in;
    logic              take_out;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [1:0]        num_wr;
    result_t           head;

    mcl_step u_step (
        .mode             (mode_reg),
        .span_has_content (content_reg),
        .char_in          (char_ch.char_in),
        .end_of_input     (char_ch.end_of_input),
        .step             (step)
    );

    // room for two results is needed before an item is taken
    assign char_ch.ready = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign take_in       = char_ch.valid && char_ch.ready;
    assign take_out      = event_ch.valid && event_ch.ready;
    assign num_wr        = take_in ? step.num_res : 2'd0;
    assign wr_ptr_plus1  = wr_ptr_reg + QPTR_W'(1);

    assign head                 = queue_reg[rd_ptr_reg];
    assign event_ch.valid       = (count_reg != '0);
    assign event_ch.event_res   = head.event_res;
    assign event_ch.data_byte   = head.data_byte;
    assign event_ch.error_code  = head.error_code;
    assign event_ch.last_of_run = head.last_of_run;

    always_comb
    begin
        mode_next    = mode_reg;
        content_next = content_reg;
        if (take_in)
        begin
            mode_next    = step.mode;
            content_next = step.span_has_content;
        end
        wr_ptr_next = wr_ptr_reg + QPTR_W'(num_wr);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(take_out);
        count_next  = count_reg + QCNT_W'(num_wr) - QCNT_W'(take_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_WHITE;
            content_reg <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            content_reg <= content_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (num_wr != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step.res0;
        end
        if (num_wr == 2'd2)
        begin
            queue_reg[wr_ptr_plus1] <= step.res1;
        end
    end

endmodule

/* hw/rtl/mcl_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the lexer result channel, bound to the top level
module mcl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] event_res,
    input logic [7:0] data_byte,
    input logic [2:0] error_code,
    input logic       last_of_run
);
    import mcl_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res) &&
        $stable(data_byte) && $stable(error_code) && $stable(last_of_run))
        else $error("result changed while stalled");

    // an error item carries a code and no byte
    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_ERROR |-> error_code != ERR_NONE && data_byte == 8'd0)
        else $error("error item with bad fields");

    a_code_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_ERROR |-> error_code == ERR_NONE)
        else $error("error code on non-error item");

    // end events always close the run of their character, and carry no byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_TOKEN_END || event_res == EV_COMMENT_END ||
        event_res == EV_INCLUDE_END) |-> last_of_run && data_byte == 8'd0)
        else $error("end event not last of run");

endmodule

bind metamath_char_lexer mcl_checker u_mcl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (event_ch.valid),
    .out_ready   (event_ch.ready),
    .event_res   (event_ch.event_res),
    .data_byte   (event_ch.data_byte),
    .error_code  (event_ch.error_code),
    .last_of_run (event_ch.last_of_run)
);
